[hdl/swrd_pkg.sv]
// Shared types and constants for the sliding-window repeat detector.
`timescale 1ns / 1ps

package swrd_pkg;

  // Width of position values broadcast to the cells; covers DEPTH up to 1024 plus a
  // full 7-bit pattern length.
  localparam int CNT_W = 12;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPETITIONS = 1'd1;

  localparam logic [CFG_DATA_W-1:0] PATTERN_LEN_RST = 7'd4;
  localparam logic [CFG_DATA_W-1:0] REPETITIONS_RST = 7'd2;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic             ins;         // take a new sample this cycle
    logic             shift_mode;  // window full: shift toward slot 0
    logic [CNT_W-1:0] fill_level;  // next free slot while filling
    logic [CNT_W-1:0] wlast;       // slot of the newest sample once full
    logic             load;        // copy window into the reference line
    logic             scan;        // reference line moves up one slot
    logic             ph_zero;     // scan step is a multiple of the pattern length
    logic [CNT_W-1:0] t;           // scan step
    logic [CNT_W-1:0] tpl;         // scan step plus pattern length
    logic [CNT_W-1:0] filled;      // occupied slots
    logic [CNT_W-1:0] pl;          // effective pattern length
    logic             cnt_shift;   // match flags move toward slot 0
  } ctl_t;

endpackage

[hdl/sliding_window_repeat_detector.sv]
// Top level: configuration, sequencer and the row of window cells.
`timescale 1ns / 1ps

// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// input    | in_valid, in_stall, in_sample           | in
// result   | out_valid, out_stall, out_detected,     | out
//          | out_match_count                         |
// config   | cfg_we, cfg_index, cfg_data             | in
//
// Each item passes through these steps in order: insert, load of the reference line,
// scan of the reference line up the cell row over F = min(samples taken, W) slots,
// shifting of match flags out at slot 0 into the counter, and hand-off.
// A new item is taken while the previous result waits in the output register.
// Reset (rst_n low, synchronous) empties the window and restores the registers.
// A stalled result holds the sequencer in its last step until the register frees.

module sliding_window_repeat_detector #(
  parameter int DEPTH       = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [31:0]                        in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_detected,
  output logic [6:0]                         out_match_count,
  input  logic                               cfg_we,
  input  logic [swrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swrd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;
  localparam logic [13:0] DEPTH_P = 14'(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_COUNT,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0]    pl_cfg_r, reps_cfg_r;
  logic [6:0]    pl_eff, reps_eff;
  logic [13:0]   prod;
  logic [CW-1:0] wsize;
  logic          shift_mode;
  logic [CW-1:0] fill_level_r, fill_nxt;
  logic [CW-1:0] filled_nxt;

  logic [CW-1:0] filled_r;
  logic [6:0]    pl_r, reps_r;
  logic [CW-1:0] t_r, t_nxt;
  logic [6:0]    ph_r, ph_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_detected_r, out_detected_nxt;
  logic [6:0]    out_match_count_r, out_match_count_nxt;

  logic          accept;
  logic          out_free;
  logic [XW-1:0] cnt_x;

  logic [SAMPLE_BITS-1:0] sample_s;
  logic [SAMPLE_BITS-1:0] w_a [DEPTH];
  logic [SAMPLE_BITS-1:0] r_a [DEPTH];
  logic [DEPTH-1:0]       m_a;

  swrd_pkg::ctl_t ctl;

  generate
    if (SAMPLE_BITS <= 32) begin : g_samp_trunc
      assign sample_s = in_sample[SAMPLE_BITS-1:0];
    end else begin : g_samp_ext
      assign sample_s = {{(SAMPLE_BITS - 32){1'b0}}, in_sample};
    end
  endgenerate

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_cfg_r   <= swrd_pkg::PATTERN_LEN_RST;
      reps_cfg_r <= swrd_pkg::REPETITIONS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        swrd_pkg::REG_PATTERN_LEN: pl_cfg_r   <= cfg_data;
        swrd_pkg::REG_REPETITIONS: reps_cfg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero acts as one; clamp the window to the row length.
  assign pl_eff   = (pl_cfg_r == 7'd0) ? 7'd1 : pl_cfg_r;
  assign reps_eff = (reps_cfg_r == 7'd0) ? 7'd1 : reps_cfg_r;
  assign prod     = 14'(pl_eff) * 14'(reps_eff);
  assign wsize    = (prod > DEPTH_P) ? CW'(DEPTH) : CW'(prod);

  assign shift_mode = (fill_level_r >= wsize);
  assign fill_nxt   = (fill_level_r < CW'(DEPTH)) ? fill_level_r + CW'(1) : fill_level_r;
  assign filled_nxt = (fill_nxt < wsize) ? fill_nxt : wsize;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign cnt_x    = XW'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_level_r <= '0;
    end else if (accept) begin
      fill_level_r <= fill_nxt;
    end
  end

  // Item parameters held for the whole scan.
  always_ff @(posedge clk) begin
    if (accept) begin
      filled_r <= filled_nxt;
      pl_r     <= pl_eff;
      reps_r   <= reps_eff;
    end
  end

  always_comb begin
    state_nxt           = state_r;
    t_nxt               = t_r;
    ph_nxt              = ph_r;
    k_nxt               = k_r;
    cnt_nxt             = cnt_r;
    out_valid_nxt       = out_valid_r;
    out_detected_nxt    = out_detected_r;
    out_match_count_nxt = out_match_count_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        t_nxt     = '0;
        ph_nxt    = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (t_r == filled_r - CW'(1)) begin
          k_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = ST_COUNT;
        end else begin
          t_nxt  = t_r + CW'(1);
          ph_nxt = (ph_r == pl_r - 7'd1) ? 7'd0 : ph_r + 7'd1;
        end
      end
      ST_COUNT: begin
        // Slot 0 presents one match flag per cycle.
        cnt_nxt = cnt_r + CW'(m_a[0]);
        k_nxt   = k_r + CW'(1);
        if (k_r == filled_r - CW'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_detected_nxt    = (cnt_x >= XW'(reps_r));
          out_match_count_nxt = (cnt_x > XW'(7'd127)) ? 7'd127 : cnt_x[6:0];
          state_nxt           = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t_r               <= t_nxt;
    ph_r              <= ph_nxt;
    k_r               <= k_nxt;
    cnt_r             <= cnt_nxt;
    out_detected_r    <= out_detected_nxt;
    out_match_count_r <= out_match_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_detected    = out_detected_r;
  assign out_match_count = out_match_count_r;

  always_comb begin
    ctl.ins        = accept;
    ctl.shift_mode = shift_mode;
    ctl.fill_level = swrd_pkg::CNT_W'(fill_level_r);
    ctl.wlast      = swrd_pkg::CNT_W'(wsize) - swrd_pkg::CNT_W'(1);
    ctl.load       = (state_r == ST_LOAD);
    ctl.scan       = (state_r == ST_SCAN);
    ctl.ph_zero    = (ph_r == 7'd0);
    ctl.t          = swrd_pkg::CNT_W'(t_r);
    ctl.tpl        = swrd_pkg::CNT_W'(t_r) + swrd_pkg::CNT_W'(pl_r);
    ctl.filled     = swrd_pkg::CNT_W'(filled_r);
    ctl.pl         = swrd_pkg::CNT_W'(pl_r);
    ctl.cnt_shift  = (state_r == ST_COUNT);
  end

  generate
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [SAMPLE_BITS-1:0] w_up;
      logic [SAMPLE_BITS-1:0] r_dn;
      logic                   m_up;

      if (g == DEPTH - 1) begin : g_top
        assign w_up = '0;
        assign m_up = 1'b0;
      end else begin : g_mid
        assign w_up = w_a[g+1];
        assign m_up = m_a[g+1];
      end

      if (g == 0) begin : g_bot
        assign r_dn = '0;
      end else begin : g_up
        assign r_dn = r_a[g-1];
      end

      swrd_cell #(
        .IDX (g),
        .SB  (SAMPLE_BITS)
      ) u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .sample (sample_s),
        .w_up   (w_up),
        .r_dn   (r_dn),
        .m_up   (m_up),
        .w      (w_a[g]),
        .r      (r_a[g]),
        .m      (m_a[g])
      );
    end
  endgenerate

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the hand-off step");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_COUNT) |->
      (filled_r != '0 && t_r < filled_r && (state_r == ST_SCAN || k_r < filled_r)))
    else $error("scan or count step beyond the filled span");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_LOAD))
    else $error("accepted item did not start a scan");

endmodule

[hdl/swrd_cell.sv]
// One window slot: sample, reference copy and match flag.
`timescale 1ns / 1ps

module swrd_cell #(
  parameter int IDX = 0,
  parameter int SB  = 32
) (
  input  logic           clk,
  input  swrd_pkg::ctl_t ctl,
  input  logic [SB-1:0]  sample,
  input  logic [SB-1:0]  w_up,
  input  logic [SB-1:0]  r_dn,
  input  logic           m_up,
  output logic [SB-1:0]  w,
  output logic [SB-1:0]  r,
  output logic           m
);

  localparam logic [swrd_pkg::CNT_W-1:0] POS = swrd_pkg::CNT_W'(IDX);

  logic [SB-1:0] w_r, w_nxt;
  logic [SB-1:0] r_r, r_nxt;
  logic          m_r, m_nxt;
  logic          en;
  logic          hit;

  // Slots below the pattern length form the base and are not counted, except for
  // a pattern of one.
  assign en = (POS < ctl.filled) &&
              ((ctl.pl == swrd_pkg::CNT_W'(1)) || (POS >= ctl.pl));

  // After t steps this slot holds the sample from t slots below; the step that
  // lands in the base block is the one to compare.
  assign hit = ctl.scan && ctl.ph_zero && (ctl.t <= POS) && (ctl.tpl > POS) &&
               en && (r_r == w_r);

  always_comb begin
    w_nxt = w_r;
    if (ctl.ins) begin
      if (ctl.shift_mode) begin
        if (POS == ctl.wlast) begin
          w_nxt = sample;
        end else if (POS < ctl.wlast) begin
          w_nxt = w_up;
        end
      end else if (POS == ctl.fill_level) begin
        w_nxt = sample;
      end
    end
  end

  always_comb begin
    r_nxt = r_r;
    if (ctl.load) begin
      r_nxt = w_r;
    end else if (ctl.scan) begin
      r_nxt = r_dn;
    end
  end

  always_comb begin
    m_nxt = m_r;
    if (ctl.load) begin
      m_nxt = 1'b0;
    end else if (hit) begin
      m_nxt = 1'b1;
    end else if (ctl.cnt_shift) begin
      m_nxt = m_up;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    r_r <= r_nxt;
    m_r <= m_nxt;
  end

  assign w = w_r;
  assign r = r_r;
  assign m = m_r;

endmodule

[tb/sliding_window_repeat_detector_tb.sv]
// Testbench for the sliding-window repeat detector: scoreboard and randomized streams.
`timescale 1ns / 1ps

module sliding_window_repeat_detector_tb;

  localparam int WIN_DEPTH   = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 1600;

  typedef struct packed {
    logic       detected;
    logic [6:0] match_count;
  } repeat_result_t;

  // Window predictor and the queue of results it has computed.
  class repeat_scoreboard;
    logic [31:0]    slots [WIN_DEPTH];
    int             fill;
    int             written;
    logic [6:0]     pattern_len;
    logic [6:0]     repetitions;
    repeat_result_t expected_q[$];
    int             checked;
    int             errors;

    function new();
      fill        = 0;
      written     = 0;
      pattern_len = swrd_pkg::PATTERN_LEN_RST;
      repetitions = swrd_pkg::REPETITIONS_RST;
      checked     = 0;
      errors      = 0;
    endfunction

    function void set_reg(logic [swrd_pkg::CFG_IDX_W-1:0] idx,
                          logic [swrd_pkg::CFG_DATA_W-1:0] val);
      if (idx == swrd_pkg::REG_PATTERN_LEN) begin
        pattern_len = val;
      end else begin
        repetitions = val;
      end
    endfunction

    function int window_len(logic [6:0] p, logic [6:0] r);
      int pl;
      int reps;
      int w;
      pl   = (p == 0) ? 1 : p;
      reps = (r == 0) ? 1 : r;
      w    = pl * reps;
      return (w > WIN_DEPTH) ? WIN_DEPTH : w;
    endfunction

    // A window that grows past the written slots would read undefined entries.
    function bit fits(logic [6:0] p, logic [6:0] r);
      int w;
      w = window_len(p, r);
      return ((fill < w) ? fill : w) <= written;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(logic [31:0] value);
      int             pl;
      int             reps;
      int             w;
      int             filled;
      int             count;
      int             i;
      repeat_result_t res;
      pl   = (pattern_len == 0) ? 1 : pattern_len;
      reps = (repetitions == 0) ? 1 : repetitions;
      w    = window_len(pattern_len, repetitions);
      if (fill >= w) begin
        // Full: shift toward slot 0, newest lands at the top.
        for (i = 0; i < w - 1; i++) slots[i] = slots[i + 1];
        slots[w - 1] = value;
      end else begin
        slots[fill] = value;
        if (fill + 1 > written) written = fill + 1;
      end
      if (fill < WIN_DEPTH) fill++;
      filled = (fill < w) ? fill : w;
      count  = 0;
      for (i = 0; i < filled; i++) begin
        if (pl == 1 || i >= pl) begin
          if (slots[i % pl] == slots[i]) count++;
        end
      end
      res.detected    = (count >= reps);
      res.match_count = (count > 127) ? 7'd127 : count[6:0];
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic detected, logic [6:0] match_count);
      repeat_result_t exp_res;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", checked));
      end else begin
        exp_res = expected_q.pop_front();
        if (detected !== exp_res.detected)
          report($sformatf("result %0d: detected %0b, want %0b",
                           checked, detected, exp_res.detected));
        if (match_count !== exp_res.match_count)
          report($sformatf("result %0d: match_count %0d, want %0d",
                           checked, match_count, exp_res.match_count));
      end
    endtask

    task finish_check();
      if (expected_q.size() != 0)
        report($sformatf("%0d results never arrived", expected_q.size()));
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [31:0]                     in_sample;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_detected;
  logic [6:0]                      out_match_count;
  logic                            cfg_we;
  logic [swrd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [swrd_pkg::CFG_DATA_W-1:0] cfg_data;

  repeat_scoreboard sb = new();

  logic [31:0] base_pat [128];
  int          stream_period;
  int          noise_pct;
  int          stream_pos;
  int          items_sent;
  int          results_seen = 0;

  sliding_window_repeat_detector #(
    .DEPTH      (WIN_DEPTH),
    .SAMPLE_BITS(32)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_detected   (out_detected),
    .out_match_count(out_match_count),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_detected, out_match_count);
      results_seen++;
    end
  end

  // Values drawn from a tiny set collide often and give partial matches.
  function logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function logic [31:0] next_sample();
    logic [31:0] v;
    if ($urandom_range(0, 99) < noise_pct) begin
      v = pick_value();
    end else begin
      v = base_pat[stream_pos % stream_period];
    end
    stream_pos++;
    return v;
  endfunction

  task new_pattern(int period, int noise);
    int i;
    stream_period = period;
    noise_pct     = noise;
    stream_pos    = 0;
    for (i = 0; i < period; i++) begin
      base_pat[i] = $urandom_range(0, 1) ? $urandom : pick_value();
    end
  endtask

  task drive_sample(logic [31:0] value);
    @(negedge clk);
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(value);
    items_sent++;
  endtask

  task wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task write_regs(logic [6:0] p, logic [6:0] r);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= swrd_pkg::REG_PATTERN_LEN;
    cfg_data  <= p;
    @(posedge clk);
    sb.set_reg(swrd_pkg::REG_PATTERN_LEN, p);
    @(negedge clk);
    cfg_index <= swrd_pkg::REG_REPETITIONS;
    cfg_data  <= r;
    @(posedge clk);
    sb.set_reg(swrd_pkg::REG_REPETITIONS, r);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Once drained, reconfigure if the new window fits the written slots, then stream n items in bursts with random gaps.
  task run_phase(logic [6:0] p, logic [6:0] r, int n);
    int left;
    int burst;
    int gap;
    int j;
    wait_idle();
    if (sb.fits(p, r)) write_regs(p, r);
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (j = 0; j < burst && left > 0; j++) begin
        drive_sample(next_sample());
        left--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_valid  <= 1'b0;
        in_sample <= $urandom;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task pick_config(output logic [6:0] p, output logic [6:0] r);
    int tries;
    tries = 0;
    do begin
      case ($urandom_range(0, 9))
        0: begin
          p = 7'd1;
          r = 7'($urandom_range(0, 127));
        end
        1: begin
          p = 7'($urandom_range(0, 127));
          r = 7'($urandom_range(0, 127));
        end
        2: begin
          p = ($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom_range(60, 127));
          r = 7'($urandom_range(0, 3));
        end
        default: begin
          p = 7'($urandom_range(1, 8));
          r = 7'($urandom_range(1, 8));
        end
      endcase
      tries++;
    end while (!sb.fits(p, r) && tries < 20);
    if (!sb.fits(p, r)) begin
      p = sb.pattern_len;
      r = sb.repetitions;
    end
  endtask

  // Receiver: stall pattern changes per segment; one long hold-off fills the block.
  initial begin
    int  mode;
    int  seg;
    int  per;
    int  on;
    int  k;
    bit  held;
    out_stall = 1'b0;
    held      = 1'b0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(20, 200);
      per  = $urandom_range(2, 6);
      on   = $urandom_range(1, per - 1);
      for (k = 0; k < seg; k++) begin
        @(negedge clk);
        if (!held && results_seen >= 30) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
          held = 1'b1;
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ((k % per) < on);
          endcase
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [6:0] p;
    logic [6:0] r;
    int         period;
    int         noise;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample    = '0;
    cfg_we       = 1'b0;
    cfg_index    = swrd_pkg::REG_PATTERN_LEN;
    cfg_data     = '0;
    items_sent   = 0;
    stream_period = 1;
    noise_pct     = 0;
    stream_pos    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset config while filling: field extremes, two slots match their base.
    drive_sample(32'h0000_0000);
    drive_sample(32'hFFFF_FFFF);
    drive_sample(32'h0000_0001);
    drive_sample(32'h8000_0000);
    drive_sample(32'h0000_0000);
    drive_sample(32'hFFFF_FFFF);
    @(negedge clk);
    in_valid <= 1'b0;

    // Fill all slots under the largest window so later configs never read unwritten ones.
    new_pattern(8, 5);
    run_phase(7'd8, 7'd8, 60);

    // Zero pattern length and zero repetitions both act as one.
    new_pattern(1, 0);
    run_phase(7'd0, 7'd0, 2);
    run_phase(7'd1, 7'd64, 3);
    // Pattern longer than the clamped window: every slot skipped.
    new_pattern(5, 0);
    run_phase(7'd127, 7'd127, 2);
    run_phase(7'd64, 7'd1, 2);
    new_pattern(1, 0);
    run_phase(7'd0, 7'd5, 3);
    new_pattern(3, 0);
    run_phase(7'd3, 7'd0, 2);
    new_pattern(2, 0);
    run_phase(7'd2, 7'd64, 3);

    while (items_sent < ITEM_TARGET) begin
      pick_config(p, r);
      case ($urandom_range(0, 9))
        0:       period = $urandom_range(1, 16);
        default: period = (p == 0) ? 1 : p;
      endcase
      case ($urandom_range(0, 9))
        0:       noise = 100;
        1, 2:    noise = 0;
        default: noise = $urandom_range(0, 10);
      endcase
      new_pattern(period, noise);
      run_phase(p, r, $urandom_range(20, 100));
    end

    wait_idle();
    repeat (200) @(negedge clk);
    sb.finish_check();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/swrd_pkg.sv
hdl/swrd_cell.sv
hdl/sliding_window_repeat_detector.sv
tb/sliding_window_repeat_detector_tb.sv
